### hdl/gwl_pkg.sv
package gwl_pkg;

  localparam int IDX_W   = 17;
  localparam int X_W     = 22;
  localparam int CP_W    = 21;
  localparam int LH_W    = 16;
  localparam int Y_W     = 32;
  localparam int CFG_W   = 22;
  localparam int CFG_IDX_W = 1;

  localparam logic [IDX_W-1:0] MAX_CHARS  = 17'h10000;
  localparam logic [CP_W-1:0]  CP_NEWLINE = 21'd10;
  localparam logic [CP_W-1:0]  CP_SPACE   = 21'd32;

  localparam logic [X_W-1:0]  MAX_WIDTH_RST   = 22'h3FFFFF;
  localparam logic [LH_W-1:0] LINE_HEIGHT_RST = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_WIDTH   = 1'b0,
    REG_LINE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic [X_W-1:0]  x_end;
    logic            last_char;
    logic            empty_text;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] start_char;
    logic [IDX_W-1:0] end_char;
    logic [Y_W-1:0]   y_offset;
    logic [X_W-1:0]   line_width;
    logic             last_line;
  } out_item_t;

endpackage

### hdl/greedy_line_wrapper.sv
// Greedy line wrapper.
// Input channel (in_valid / in_stall / in_data): one decoded code point per
// item with its cumulative end x, a last-character flag and an empty-text
// flag. Result channel (out_valid / out_stall / out_data): line records
// with start and end character index, y offset, width and a last-line flag.
// An item produces zero, one or two line records.
// Config port (cfg_we / cfg_idx / cfg_data): index 0 is max_width, index 1
// is line_height; write only while no text is in flight.
// An accepted item is held in the input register until the output queue
// has room for its records, which then land in a four-entry output queue;
// out_data shows the queue head, and out_valid is high while it is not empty.
// Throughput: one item per cycle while the output queue has room for two
// records; the queue drains one record per cycle while out_stall is low.
// Reset (rst_n low, synchronous): text state, queue and input register are
// cleared, max_width returns to 4194303 and line_height to 1024.
// When the receiver stalls, records pile up in the queue; once fewer than
// two entries are free, the input register holds and in_stall rises.
module greedy_line_wrapper
  import gwl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [X_W-1:0]  max_width_r;
  logic [LH_W-1:0] line_height_r;

  // input register
  logic     in_vld_r;
  in_item_t in_r;

  // text state
  logic [IDX_W-1:0] char_index_r, char_index_nxt;
  logic [IDX_W-1:0] line_begin_r, line_begin_nxt;
  logic [X_W-1:0]   line_begin_x_r, line_begin_x_nxt;
  logic [IDX_W-1:0] word_end_r, word_end_nxt;
  logic [X_W-1:0]   word_end_x_r, word_end_x_nxt;
  logic [X_W-1:0]   previous_x_r, previous_x_nxt;
  logic [Y_W-1:0]   y_accum_r, y_accum_nxt;

  // output queue
  out_item_t  q_mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  logic       go;
  logic       pop;
  logic [1:0] n_res;
  out_item_t  res0, res1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_width_r   <= MAX_WIDTH_RST;
      line_height_r <= LINE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MAX_WIDTH:   max_width_r   <= cfg_data[X_W-1:0];
        REG_LINE_HEIGHT: line_height_r <= cfg_data[LH_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: process the held item when the queue has room for two records
  assign go        = in_vld_r && (cnt_r <= 3'd2);
  assign in_stall  = in_vld_r && !(cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q_mem_r[rp_r];

  // load the input register, hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
  end

  function automatic logic [X_W-1:0] sub_floor(input logic [X_W-1:0] a,
                                               input logic [X_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
    return (i < MAX_CHARS) ? (i + 1'b1) : MAX_CHARS;
  endfunction

  function automatic logic [Y_W-1:0] add_y(input logic [Y_W-1:0] y,
                                           input logic [LH_W-1:0] h);
    logic [Y_W:0] s;
    s = {1'b0, y} + {{(Y_W+1-LH_W){1'b0}}, h};
    return s[Y_W] ? {Y_W{1'b1}} : s[Y_W-1:0];
  endfunction

  // line break logic for the held item
  always_comb begin
    logic [IDX_W-1:0] i, nxt, lb, we_t;
    logic [X_W-1:0]   lbx, wex_t, w;
    logic [Y_W-1:0]   y;
    logic             brk;

    i   = char_index_r;
    nxt = next_index(i);
    lb  = line_begin_r;
    lbx = line_begin_x_r;
    y   = y_accum_r;
    we_t  = word_end_r;
    wex_t = word_end_x_r;
    w   = '0;
    brk = 1'b0;

    char_index_nxt   = char_index_r;
    line_begin_nxt   = line_begin_r;
    line_begin_x_nxt = line_begin_x_r;
    word_end_nxt     = word_end_r;
    word_end_x_nxt   = word_end_x_r;
    previous_x_nxt   = previous_x_r;
    y_accum_nxt      = y_accum_r;
    n_res            = 2'd0;
    res0             = '0;
    res1             = '0;

    if (in_r.empty_text) begin
      // empty text: one zero line, drop the text state
      n_res          = 2'd1;
      res0.last_line = 1'b1;
      char_index_nxt   = '0;
      line_begin_nxt   = '0;
      line_begin_x_nxt = '0;
      word_end_nxt     = '0;
      word_end_x_nxt   = '0;
      previous_x_nxt   = '0;
      y_accum_nxt      = '0;
    end else begin
      if (in_r.codepoint == CP_NEWLINE) begin
        // forced break, newline left out of the line
        w = (i != '0 && lb < i) ? sub_floor(previous_x_r, lbx) : '0;
        res0  = '{start_char: lb, end_char: i, y_offset: y, line_width: w,
                  last_line: 1'b0};
        n_res = 2'd1;
        y     = add_y(y, line_height_r);
        lb    = nxt;
        lbx   = in_r.x_end;
        we_t  = nxt;
        wex_t = in_r.x_end;
      end else begin
        if (in_r.codepoint == CP_SPACE) begin
          we_t  = i;
          wex_t = in_r.x_end;
        end
        brk = (sub_floor(in_r.x_end, lbx) > max_width_r) && (i > lb);
        if (brk) begin
          if (we_t > lb) begin
            // break after the last space, skip it
            w    = sub_floor(wex_t, lbx);
            res0 = '{start_char: lb, end_char: we_t, y_offset: y, line_width: w,
                     last_line: 1'b0};
            lb   = next_index(we_t);
            lbx  = wex_t;
          end else begin
            // no space: break before this character
            w    = sub_floor(previous_x_r, lbx);
            res0 = '{start_char: lb, end_char: i, y_offset: y, line_width: w,
                     last_line: 1'b0};
            lb   = i;
            lbx  = previous_x_r;
          end
          n_res = 2'd1;
          y     = add_y(y, line_height_r);
          we_t  = lb;
          wex_t = lbx;
        end
      end

      if (in_r.last_char) begin
        // close the final line and start a new text
        w = (lb < nxt) ? sub_floor(in_r.x_end, lbx) : '0;
        if (n_res == 2'd0) begin
          res0 = '{start_char: lb, end_char: nxt, y_offset: y, line_width: w,
                   last_line: 1'b1};
        end else begin
          res1 = '{start_char: lb, end_char: nxt, y_offset: y, line_width: w,
                   last_line: 1'b1};
        end
        n_res = n_res + 2'd1;
        char_index_nxt   = '0;
        line_begin_nxt   = '0;
        line_begin_x_nxt = '0;
        word_end_nxt     = '0;
        word_end_x_nxt   = '0;
        previous_x_nxt   = '0;
        y_accum_nxt      = '0;
      end else begin
        char_index_nxt   = nxt;
        previous_x_nxt   = in_r.x_end;
        line_begin_nxt   = lb;
        line_begin_x_nxt = lbx;
        word_end_nxt     = we_t;
        word_end_x_nxt   = wex_t;
        y_accum_nxt      = y;
      end
    end
  end

  // advance the text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_index_r   <= '0;
      line_begin_r   <= '0;
      line_begin_x_r <= '0;
      word_end_r     <= '0;
      word_end_x_r   <= '0;
      previous_x_r   <= '0;
      y_accum_r      <= '0;
    end else if (go) begin
      char_index_r   <= char_index_nxt;
      line_begin_r   <= line_begin_nxt;
      line_begin_x_r <= line_begin_x_nxt;
      word_end_r     <= word_end_nxt;
      word_end_x_r   <= word_end_x_nxt;
      previous_x_r   <= previous_x_nxt;
      y_accum_r      <= y_accum_nxt;
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (go && n_res != 2'd0) begin
      q_mem_r[wp_r] <= res0;
    end
    if (go && n_res == 2'd2) begin
      q_mem_r[wp_r + 2'd1] <= res1;
    end
  end

  // output queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (go) begin
        wp_r <= wp_r + n_res;
      end
      if (pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + (go ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
    end
  end

endmodule

### hdl/gwl_checker.sv
module gwl_checker
  import gwl_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input in_item_t             in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_item_t            out_data
);

  // hold a stalled record
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output record changed or dropped");

  // hold a stalled input item
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed or dropped");

  // reset empties the queue
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // reset frees the input side
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // an empty line has no width
  a_empty_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.start_char == out_data.end_char)
      |-> out_data.line_width == '0)
    else $error("empty line with nonzero width");

endmodule

bind greedy_line_wrapper gwl_checker u_gwl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
